### hdl/hermitian_rank2_update_defines.svh
// Assertion helpers for the Hermitian rank-2 update block.
// Each check is sampled on the rising edge of i_clk and is held off while reset is asserted.
`ifndef HERMITIAN_RANK2_UPDATE_DEFINES_SVH
`define HERMITIAN_RANK2_UPDATE_DEFINES_SVH

`ifndef SYNTH
`define HRU_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define HRU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define HRU_ASSERT_SAME(lbl, pre, post, msg)
`define HRU_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### hdl/hru_pkg.sv
`timescale 1ns / 1ps

package hru_pkg;

    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;
    localparam int ORDER_W       = 7;
    localparam int ADDR_W        = 4;
    localparam int MAX_ORDER_DEF = 64;
    localparam int FRAC_BITS_DEF = 27;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] REG_ALPHA_RE = 2'd0;
    localparam logic [1:0] REG_ALPHA_IM = 2'd1;
    localparam logic [1:0] REG_LOWER    = 2'd2;
    localparam logic [1:0] REG_ORDER    = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_cplx;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             upd;
        logic             diag;
    } t_tag;

endpackage

### hdl/hermitian_rank2_update.sv
`timescale 1ns / 1ps
// Pipeline: an update transaction's result passes through five register stages before it
// reaches the output.
// Throughput: one transaction per cycle; an output stall backs up stage by stage, and
// the input stalls once every stage holds a transaction. A load writes the stores when accepted.
// Reset: synchronous, active low; it clears the configuration registers and the
// stage valid bits. The x and y stores are not cleared and hold nothing until loaded.
`include "hermitian_rank2_update_defines.svh"

module hermitian_rank2_update #(
    parameter int MAX_ORDER = hru_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = hru_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hru_pkg::ADDR_W-1:0]          paddr,
    input  logic [hru_pkg::DATA_W-1:0]          pwdata,
    output logic [hru_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [hru_pkg::IDX_W-1:0]           i_row_index,
    input  logic [hru_pkg::IDX_W-1:0]           i_col_index,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_x_real,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_x_imag,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_y_real,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_y_imag,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_elem_real,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_elem_imag,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hru_pkg::IDX_W-1:0]           o_out_row,
    output logic [hru_pkg::IDX_W-1:0]           o_out_col,
    output logic signed [hru_pkg::DATA_W-1:0]   o_new_real,
    output logic signed [hru_pkg::DATA_W-1:0]   o_new_imag,
    output logic                                o_saturated
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = ($clog2(MAX_ORDER + 1) > hru_pkg::ORDER_W) ?
                        $clog2(MAX_ORDER + 1) : hru_pkg::ORDER_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_ORDER);

    logic signed [hru_pkg::DATA_W-1:0] r_alpha_re;
    logic signed [hru_pkg::DATA_W-1:0] r_alpha_im;
    logic                              r_lower;
    logic [hru_pkg::ORDER_W-1:0]       r_order;

    logic            in_acc;
    logic            en1;
    logic            d_ready;
    logic            wr_en;
    logic [AW-1:0]   addr_row;
    logic [AW-1:0]   addr_col;
    logic [CW-1:0]   n_eff;
    logic [CW-1:0]   row_ext;
    logic [CW-1:0]   col_ext;
    logic            tri_ok;
    logic            upd_pre;
    hru_pkg::t_cplx  x_wdata;
    hru_pkg::t_cplx  y_wdata;
    hru_pkg::t_cplx  x_row;
    hru_pkg::t_cplx  x_col;
    hru_pkg::t_cplx  y_row;
    hru_pkg::t_cplx  y_col;
    logic            col_nz;

    logic            r_v1;
    hru_pkg::t_tag   r_tag;
    hru_pkg::t_cplx  r_elem;
    hru_pkg::t_tag   d_tag;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_re <= '0;
            r_alpha_im <= '0;
            r_lower    <= 1'b0;
            r_order    <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                hru_pkg::REG_ALPHA_RE: r_alpha_re <= pwdata;
                hru_pkg::REG_ALPHA_IM: r_alpha_im <= pwdata;
                hru_pkg::REG_LOWER:    r_lower    <= pwdata[0];
                hru_pkg::REG_ORDER:    r_order    <= pwdata[hru_pkg::ORDER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hru_pkg::REG_ALPHA_RE: prdata = r_alpha_re;
            hru_pkg::REG_ALPHA_IM: prdata = r_alpha_im;
            hru_pkg::REG_LOWER:    prdata = hru_pkg::DATA_W'(r_lower);
            hru_pkg::REG_ORDER:    prdata = hru_pkg::DATA_W'(r_order);
            default:               prdata = '0;
        endcase
    end

    assign en1        = !r_v1 || d_ready;
    assign o_in_ready = en1;
    assign in_acc     = i_in_valid && o_in_ready;

    // An order above the store depth behaves as the store depth.
    always_comb begin
        n_eff   = (CW'(r_order) > MAX_N) ? MAX_N : CW'(r_order);
        row_ext = CW'(i_row_index);
        col_ext = CW'(i_col_index);
        tri_ok  = r_lower ? (i_row_index >= i_col_index) : (i_row_index <= i_col_index);
        upd_pre = (n_eff != '0) && (row_ext < n_eff) && (col_ext < n_eff) &&
                  ((r_alpha_re != '0) || (r_alpha_im != '0)) && tri_ok;
    end

    assign addr_row   = AW'(i_row_index);
    assign addr_col   = AW'(i_col_index);
    assign wr_en      = in_acc && (i_opcode == hru_pkg::OP_LOAD) && (row_ext < MAX_N);
    assign x_wdata.re = i_x_real;
    assign x_wdata.im = i_x_imag;
    assign y_wdata.re = i_y_real;
    assign y_wdata.im = i_y_imag;

    hru_vstore #(
        .DEPTH(MAX_ORDER)
    ) u_x_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (addr_row),
        .i_wr_data   (x_wdata),
        .i_rd_en     (en1),
        .i_rd_addr_a (addr_row),
        .i_rd_addr_b (addr_col),
        .o_rd_data_a (x_row),
        .o_rd_data_b (x_col)
    );

    hru_vstore #(
        .DEPTH(MAX_ORDER)
    ) u_y_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (addr_row),
        .i_wr_data   (y_wdata),
        .i_rd_en     (en1),
        .i_rd_addr_a (addr_row),
        .i_rd_addr_b (addr_col),
        .o_rd_data_a (y_row),
        .o_rd_data_b (y_col)
    );

    // Stage 1 holds the store read data; only update transactions enter it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid && (i_opcode == hru_pkg::OP_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_tag.row  <= i_row_index;
            r_tag.col  <= i_col_index;
            r_tag.upd  <= upd_pre;
            r_tag.diag <= (i_row_index == i_col_index);
            r_elem.re  <= i_elem_real;
            r_elem.im  <= i_elem_imag;
        end
    end

    // The column entries of x and y both zero leave the element unchanged.
    assign col_nz = (x_col != '0) || (y_col != '0);

    always_comb begin
        d_tag     = r_tag;
        d_tag.upd = r_tag.upd && col_nz;
    end

    hru_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alpha_re (r_alpha_re),
        .i_alpha_im (r_alpha_im),
        .i_valid    (r_v1),
        .o_ready    (d_ready),
        .i_tag      (d_tag),
        .i_elem     (r_elem),
        .i_x_row    (x_row),
        .i_y_row    (y_row),
        .i_x_col    (x_col),
        .i_y_col    (y_col),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_row      (o_out_row),
        .o_col      (o_out_col),
        .o_new_re   (o_new_real),
        .o_new_im   (o_new_imag),
        .o_sat      (o_saturated)
    );

    `HRU_ASSERT_NEXT(a_load_skips_pipe, in_acc && (i_opcode == hru_pkg::OP_LOAD), !r_v1, "load entered pipeline")
    `HRU_ASSERT_NEXT(a_stage1_holds, r_v1 && !d_ready, r_v1 && $stable(r_tag) && $stable(r_elem), "stage 1 lost data on stall")
    `HRU_ASSERT_SAME(a_diag_tag, r_v1 && r_tag.diag, r_tag.row == r_tag.col, "diagonal tag on off-diagonal element")

endmodule

### hdl/hru_vstore.sv
`timescale 1ns / 1ps

module hru_vstore #(
    parameter int DEPTH = hru_pkg::MAX_ORDER_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  hru_pkg::t_cplx                               i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output hru_pkg::t_cplx                               o_rd_data_a,
    output hru_pkg::t_cplx                               o_rd_data_b
);

    hru_pkg::t_cplx r_mem [DEPTH];
    hru_pkg::t_cplx r_rd_a;
    hru_pkg::t_cplx r_rd_b;

    // Reads see the contents before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### hdl/hru_datapath.sv
`timescale 1ns / 1ps

module hru_datapath #(
    parameter int FRAC_BITS = hru_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_alpha_re,
    input  logic signed [hru_pkg::DATA_W-1:0]   i_alpha_im,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hru_pkg::t_tag                       i_tag,
    input  hru_pkg::t_cplx                      i_elem,
    input  hru_pkg::t_cplx                      i_x_row,
    input  hru_pkg::t_cplx                      i_y_row,
    input  hru_pkg::t_cplx                      i_x_col,
    input  hru_pkg::t_cplx                      i_y_col,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hru_pkg::IDX_W-1:0]           o_row,
    output logic [hru_pkg::IDX_W-1:0]           o_col,
    output logic signed [hru_pkg::DATA_W-1:0]   o_new_re,
    output logic signed [hru_pkg::DATA_W-1:0]   o_new_im,
    output logic                                o_sat
);

    localparam int DW = hru_pkg::DATA_W;
    localparam int PW = 2 * DW;
    // Rounded products need PW - FRAC_BITS bits; three more cover four terms plus the element.
    localparam int SW = PW - FRAC_BITS + 3;
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [SW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = (p + HALF) >>> FRAC_BITS;
        return s[SW-1:0];
    endfunction

    function automatic logic clipped(input logic signed [SW-1:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(DW-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(DW-1){1'b0}}};
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] ext(input logic signed [DW-1:0] a);
        return {{(SW-DW){a[DW-1]}}, a};
    endfunction

    logic en2;
    logic en3;
    logic en4;
    logic en5;

    // Stage 2: alpha products.
    logic                  r2_v;
    logic signed [PW-1:0]  r2_p [8];
    logic signed [PW-1:0]  n2_p [8];
    hru_pkg::t_tag         r2_tag;
    hru_pkg::t_cplx        r2_elem;
    hru_pkg::t_cplx        r2_x_row;
    hru_pkg::t_cplx        r2_y_row;

    // Stage 3: saturated temp1 and temp2.
    logic                  r3_v;
    logic signed [DW-1:0]  r3_t [4];
    logic signed [DW-1:0]  n3_t [4];
    logic                  r3_tclip;
    logic                  n3_tclip;
    hru_pkg::t_tag         r3_tag;
    hru_pkg::t_cplx        r3_elem;
    hru_pkg::t_cplx        r3_x_row;
    hru_pkg::t_cplx        r3_y_row;
    logic signed [SW-1:0]  q1 [8];
    logic signed [SW-1:0]  s1 [4];

    // Stage 4: row products.
    logic                  r4_v;
    logic signed [PW-1:0]  r4_p [8];
    logic signed [PW-1:0]  n4_p [8];
    logic                  r4_tclip;
    hru_pkg::t_tag         r4_tag;
    hru_pkg::t_cplx        r4_elem;
    logic signed [SW-1:0]  q2 [8];
    logic signed [SW-1:0]  sum_re;
    logic signed [SW-1:0]  sum_im;

    // Stage 5: output register.
    logic                  r_out_valid;
    logic [hru_pkg::IDX_W-1:0] r_out_row;
    logic [hru_pkg::IDX_W-1:0] r_out_col;
    logic signed [DW-1:0]  r_out_re;
    logic signed [DW-1:0]  r_out_im;
    logic                  r_out_sat;
    logic signed [DW-1:0]  n_out_re;
    logic signed [DW-1:0]  n_out_im;
    logic                  n_out_sat;

    assign en5 = !r_out_valid || i_ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign o_ready = en2;

    always_comb begin
        n2_p[0] = $signed(i_alpha_re) * $signed(i_y_col.re);
        n2_p[1] = $signed(i_alpha_im) * $signed(i_y_col.im);
        n2_p[2] = $signed(i_alpha_im) * $signed(i_y_col.re);
        n2_p[3] = $signed(i_alpha_re) * $signed(i_y_col.im);
        n2_p[4] = $signed(i_alpha_re) * $signed(i_x_col.re);
        n2_p[5] = $signed(i_alpha_im) * $signed(i_x_col.im);
        n2_p[6] = $signed(i_alpha_re) * $signed(i_x_col.im);
        n2_p[7] = $signed(i_alpha_im) * $signed(i_x_col.re);
    end

    // temp1 = alpha * conj(y[col]), temp2 = conj(alpha * x[col]).
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            q1[k] = rnd(r2_p[k]);
        end
        s1[0] = q1[0] + q1[1];
        s1[1] = q1[2] - q1[3];
        s1[2] = q1[4] - q1[5];
        s1[3] = -(q1[6] + q1[7]);
        n3_tclip = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n3_t[k] = sat(s1[k]);
            n3_tclip = n3_tclip | clipped(s1[k]);
        end
    end

    always_comb begin
        n4_p[0] = $signed(r3_x_row.re) * r3_t[0];
        n4_p[1] = $signed(r3_x_row.im) * r3_t[1];
        n4_p[2] = $signed(r3_y_row.re) * r3_t[2];
        n4_p[3] = $signed(r3_y_row.im) * r3_t[3];
        n4_p[4] = $signed(r3_x_row.re) * r3_t[1];
        n4_p[5] = $signed(r3_x_row.im) * r3_t[0];
        n4_p[6] = $signed(r3_y_row.re) * r3_t[3];
        n4_p[7] = $signed(r3_y_row.im) * r3_t[2];
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            q2[k] = rnd(r4_p[k]);
        end
        sum_re = ext(r4_elem.re) + q2[0] - q2[1] + q2[2] - q2[3];
        sum_im = ext(r4_elem.im) + q2[4] + q2[5] + q2[6] + q2[7];
        if (r4_tag.upd) begin
            n_out_re = sat(sum_re);
            if (r4_tag.diag) begin
                n_out_im  = '0;
                n_out_sat = r4_tclip | clipped(sum_re);
            end else begin
                n_out_im  = sat(sum_im);
                n_out_sat = r4_tclip | clipped(sum_re) | clipped(sum_im);
            end
        end else begin
            n_out_re  = r4_elem.re;
            n_out_im  = r4_elem.im;
            n_out_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_v <= i_valid;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
            if (en5) begin
                r_out_valid <= r4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_p     <= n2_p;
            r2_tag   <= i_tag;
            r2_elem  <= i_elem;
            r2_x_row <= i_x_row;
            r2_y_row <= i_y_row;
        end
        if (en3) begin
            r3_t     <= n3_t;
            r3_tclip <= n3_tclip;
            r3_tag   <= r2_tag;
            r3_elem  <= r2_elem;
            r3_x_row <= r2_x_row;
            r3_y_row <= r2_y_row;
        end
        if (en4) begin
            r4_p     <= n4_p;
            r4_tclip <= r3_tclip;
            r4_tag   <= r3_tag;
            r4_elem  <= r3_elem;
        end
        if (en5) begin
            r_out_row <= r4_tag.row;
            r_out_col <= r4_tag.col;
            r_out_re  <= n_out_re;
            r_out_im  <= n_out_im;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_row    = r_out_row;
    assign o_col    = r_out_col;
    assign o_new_re = r_out_re;
    assign o_new_im = r_out_im;
    assign o_sat    = r_out_sat;

endmodule
